// ===== design/ptq_pkg.sv =====
// ptq_pkg: shared codes, widths and structs of the priority task queue
// used by ptq_cell, the top level and the port checker; no dependencies
`timescale 1ns / 1ps

package ptq_pkg;

   localparam int WORD_W   = 32;
   localparam int REQ_W    = 2;
   localparam int STATUS_W = 3;
   localparam int OP_W     = 3;

   // request kinds
   localparam logic [REQ_W-1:0] REQ_INSERT   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_POP      = 2'd1;
   localparam logic [REQ_W-1:0] REQ_CANCEL   = 2'd2;
   localparam logic [REQ_W-1:0] REQ_SHUTDOWN = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_SHUT     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

   // operations broadcast to the cell row
   localparam logic [OP_W-1:0] CELL_HOLD   = 3'd0;
   localparam logic [OP_W-1:0] CELL_INSERT = 3'd1;
   localparam logic [OP_W-1:0] CELL_POP    = 3'd2;
   localparam logic [OP_W-1:0] CELL_CANCEL = 3'd3;
   localparam logic [OP_W-1:0] CELL_CLEAR  = 3'd4;

   typedef struct packed {
      logic [WORD_W-1:0] prio;
      logic [WORD_W-1:0] id;
      logic [WORD_W-1:0] handle;
   } entry_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      entry_type         ins;
      logic [WORD_W-1:0] cancel_id;
   } cmd_type;

endpackage

// ===== design/ptq_cell.sv =====
// ptq_cell: one slot of the sorted queue row, keeps one entry and its valid bit
// and shifts toward either neighbor; depends on ptq_pkg
`timescale 1ns / 1ps

module ptq_cell (
   input  logic               clock,
   input  logic               reset,
   input  ptq_pkg::cmd_type   cmd_i,
   input  logic               left_valid_i,
   input  ptq_pkg::entry_type left_entry_i,
   input  logic               left_gt_i,
   input  logic               right_valid_i,
   input  ptq_pkg::entry_type right_entry_i,
   input  logic               seen_i,
   output logic               valid_o,
   output ptq_pkg::entry_type entry_o,
   output logic               gt_o,
   output logic               dup_o,
   output logic               seen_o
);
   import ptq_pkg::*;

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   logic      new_first;

   // new key orders before the stored key, both halves compared signed
   always_comb begin
      new_first = ($signed(cmd_i.ins.prio) < $signed(entry_ff.prio)) ||
                  ((cmd_i.ins.prio == entry_ff.prio) &&
                   ($signed(cmd_i.ins.id) < $signed(entry_ff.id)));
   end

   assign gt_o   = !valid_ff || new_first;
   assign dup_o  = valid_ff && (cmd_i.ins.prio == entry_ff.prio) &&
                   (cmd_i.ins.id == entry_ff.id);
   assign seen_o = seen_i || (valid_ff && (entry_ff.id == cmd_i.cancel_id));

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      unique case (cmd_i.op)
         CELL_INSERT: begin
            if (gt_o) begin
               valid_in = left_gt_i ? left_valid_i : 1'b1;
               entry_in = left_gt_i ? left_entry_i : cmd_i.ins;
            end
         end
         CELL_POP: begin
            valid_in = right_valid_i;
            entry_in = right_entry_i;
         end
         CELL_CANCEL: begin
            if (seen_o) begin
               valid_in = right_valid_i;
               entry_in = right_entry_i;
            end
         end
         CELL_CLEAR: begin
            valid_in = 1'b0;
         end
         default: begin
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign valid_o = valid_ff;
   assign entry_o = entry_ff;

endmodule

// ===== design/priority_task_queue_with_cancel_core.sv =====
// priority_task_queue_with_cancel_core: top level of the task queue, a sorted
// row of ptq_cell slots plus request staging and a result register; uses ptq_pkg
//
//  channel  | direction | tuser               | tdata (lowest bit up)
//  ---------+-----------+---------------------+-----------------------------------
//  req_     | in        | [1:0] req_type      | priority_req, task_handle, cancel_id
//  rsp_     | out       | [2:0] status        | task_id, out_handle, out_priority
//
// each word is first captured in the request stage; then the whole cell row
// compares against it and shifts in a single step
// the next request is taken while a result still waits in the output register
// a stalled result holds the request stage; the row does not move meanwhile
// reset clears every valid bit, the id counter and the started and shut down flags
`timescale 1ns / 1ps

module priority_task_queue_with_cancel_core #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [ptq_pkg::REQ_W-1:0]               req_tuser,  // req_type
   input  logic [3*ptq_pkg::WORD_W-1:0]            req_tdata,  // priority_req, task_handle,
                                                               // cancel_id
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [ptq_pkg::STATUS_W-1:0]            rsp_tuser,  // status
   output logic [3*ptq_pkg::WORD_W-1:0]            rsp_tdata   // task_id, out_handle,
                                                               // out_priority
);
   import ptq_pkg::*;

   // request stage
   logic                busy_ff, busy_in;
   logic [REQ_W-1:0]    kind_ff;
   logic [WORD_W-1:0]   prio_ff, handle_ff, cid_ff;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [WORD_W-1:0]   tid_ff, tid_in, oh_ff, oh_in, op_ff, op_in;

   // queue control state
   logic [WORD_W-1:0]   id_counter_ff, id_counter_in;
   logic                started_ff, started_in;
   logic                quit_ff, quit_in;

   logic                accept, exec;
   logic [WORD_W-1:0]   new_id;
   cmd_type             cmd;
   logic [OP_W-1:0]     cell_op;

   // cell row wiring
   logic      [QUEUE_DEPTH-1:0] valid_v, gt_v, dup_v, seen_v;
   entry_type                   entry_v [QUEUE_DEPTH];

   logic dup_any, full, found;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !busy_ff;
   // execute once the output register is free or being emptied
   assign exec       = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign new_id     = id_counter_ff + {{(WORD_W-1){1'b0}}, 1'b1};

   assign dup_any = |dup_v;
   assign full    = valid_v[QUEUE_DEPTH-1];
   assign found   = seen_v[QUEUE_DEPTH-1];

   always_comb begin
      cmd.op         = cell_op;
      cmd.ins.prio   = prio_ff;
      cmd.ins.id     = new_id;
      cmd.ins.handle = handle_ff;
      cmd.cancel_id  = cid_ff;
   end

   genvar g;
   generate
      for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
         logic      l_valid, l_gt, r_valid, s_in;
         entry_type l_entry, r_entry;
         if (g == 0) begin : g_head
            assign l_valid = 1'b0;
            assign l_gt    = 1'b0;
            assign l_entry = '0;
            assign s_in    = 1'b0;
         end else begin : g_mid
            assign l_valid = valid_v[g-1];
            assign l_gt    = gt_v[g-1];
            assign l_entry = entry_v[g-1];
            assign s_in    = seen_v[g-1];
         end
         if (g == QUEUE_DEPTH-1) begin : g_tail
            assign r_valid = 1'b0;
            assign r_entry = '0;
         end else begin : g_body
            assign r_valid = valid_v[g+1];
            assign r_entry = entry_v[g+1];
         end
         ptq_cell u_cell (
            .clock         (clock),
            .reset         (reset),
            .cmd_i         (cmd),
            .left_valid_i  (l_valid),
            .left_entry_i  (l_entry),
            .left_gt_i     (l_gt),
            .right_valid_i (r_valid),
            .right_entry_i (r_entry),
            .seen_i        (s_in),
            .valid_o       (valid_v[g]),
            .entry_o       (entry_v[g]),
            .gt_o          (gt_v[g]),
            .dup_o         (dup_v[g]),
            .seen_o        (seen_v[g])
         );
      end
   endgenerate

   // request decode against the current row
   always_comb begin
      cell_op       = CELL_HOLD;
      status_in     = status_ff;
      tid_in        = tid_ff;
      oh_in         = oh_ff;
      op_in         = op_ff;
      id_counter_in = id_counter_ff;
      started_in    = started_ff;
      quit_in       = quit_ff;
      if (exec) begin
         status_in = ST_OK;
         tid_in    = '0;
         oh_in     = '0;
         op_in     = '0;
         unique case (kind_ff)
            REQ_INSERT: begin
               // id counter moves on every insert, even a rejected one
               id_counter_in = new_id;
               if (quit_ff) begin
                  status_in = ST_SHUT;
               end else begin
                  started_in = 1'b1;
                  if (dup_any) begin
                     tid_in = new_id;
                  end else if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     cell_op = CELL_INSERT;
                     tid_in  = new_id;
                  end
               end
            end
            REQ_POP: begin
               if (quit_ff) begin
                  status_in = ST_SHUT;
               end else if (!valid_v[0]) begin
                  status_in = ST_EMPTY;
               end else begin
                  cell_op = CELL_POP;
                  tid_in  = entry_v[0].id;
                  oh_in   = entry_v[0].handle;
                  op_in   = entry_v[0].prio;
               end
            end
            REQ_CANCEL: begin
               if (quit_ff) begin
                  status_in = ST_SHUT;
               end else if (!found) begin
                  status_in = ST_NOTFOUND;
               end else begin
                  cell_op = CELL_CANCEL;
                  tid_in  = cid_ff;
               end
            end
            REQ_SHUTDOWN: begin
               if (quit_ff) begin
                  status_in = ST_SHUT;
               end else if (started_ff) begin
                  cell_op    = CELL_CLEAR;
                  started_in = 1'b0;
                  quit_in    = 1'b1;
               end
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (exec) begin
         busy_in = 1'b0;
      end else if (accept) begin
         busy_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         id_counter_ff <= '0;
         started_ff    <= 1'b0;
         quit_ff       <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
         id_counter_ff <= id_counter_in;
         started_ff    <= started_in;
         quit_ff       <= quit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= req_tuser;
         prio_ff   <= req_tdata[WORD_W-1:0];
         handle_ff <= req_tdata[2*WORD_W-1:WORD_W];
         cid_ff    <= req_tdata[3*WORD_W-1:2*WORD_W];
      end
      status_ff <= status_in;
      tid_ff    <= tid_in;
      oh_ff     <= oh_in;
      op_ff     <= op_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {op_ff, oh_ff, tid_ff};

endmodule

// ===== design/ptq_checker.sv =====
// ptq_checker: port-level checks of the task queue top level, bound to it below
// depends on ptq_pkg and priority_task_queue_with_cancel_core
`timescale 1ns / 1ps

module ptq_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [ptq_pkg::STATUS_W-1:0]         rsp_tuser,
   input logic [3*ptq_pkg::WORD_W-1:0]         rsp_tdata
);
   import ptq_pkg::*;

   // a taken word occupies the request stage and drops ready, so only one is in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while previous word still staged");

   // a new result only comes out of a staged request
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result appeared without a staged request");

   // any failing status carries all-zero data
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != ST_OK)) |-> (rsp_tdata == '0))
      else $error("failing status with nonzero data");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) &&
                                       $stable(rsp_tuser)))
      else $error("stalled result changed");

endmodule

bind priority_task_queue_with_cancel_core ptq_checker u_ptq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);
